@@ rtl/core/sacc_pkg.sv @@
`default_nettype none

package sacc_pkg;

   // Operation codes carried on req_op.
   localparam logic [3:0] OP_LOAD = 4'd0;
   localparam logic [3:0] OP_AND  = 4'd1;
   localparam logic [3:0] OP_OR   = 4'd2;
   localparam logic [3:0] OP_XOR  = 4'd3;
   localparam logic [3:0] OP_NOT  = 4'd4;
   localparam logic [3:0] OP_ADD  = 4'd5;
   localparam logic [3:0] OP_SUB  = 4'd6;
   localparam logic [3:0] OP_MUL  = 4'd7;
   localparam logic [3:0] OP_DIV  = 4'd8;
   localparam logic [3:0] OP_INC  = 4'd9;
   localparam logic [3:0] OP_DEC  = 4'd10;

   // Signed 16-bit limits.
   localparam logic [15:0] SAT_MAX = 16'h7FFF;
   localparam logic [15:0] SAT_MIN = 16'h8000;

   // Width of the shared adder and the iteration count of multiply and divide.
   localparam int UNIT_W = 18;
   localparam int ITER_N = 16;
   localparam int CNT_W  = 4;

   typedef logic [UNIT_W-1:0] unit_word_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_ITER   = 5'b00100,
      ST_POST   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/sacc_addsub.sv @@
`default_nettype none

// Shared adder and subtractor used by add, subtract, increment, decrement
// and every multiply and divide iteration.
module sacc_addsub
   import sacc_pkg::*;
(
   input  wire unit_word_type x,
   input  wire unit_word_type y,
   input  wire logic          sub,
   output unit_word_type      sum
);

   unit_word_type y_eff;

   // Subtraction adds the complement with a carry in of one.
   always_comb begin
      y_eff = sub ? ~y : y;
      sum   = x + y_eff + {{(UNIT_W-1){1'b0}}, sub};
   end

endmodule

`default_nettype wire

@@ rtl/core/saturating_accumulator_alu16.sv @@
`default_nettype none

// Channel | Direction | Ports                                   | Transfer when
// req     | in        | req_op, req_operand, req_write_back     | req_valid & req_ready
// rsp     | out       | rsp_result, rsp_saturated,              | rsp_valid & rsp_ready
//         |           | rsp_divide_by_zero                      |
//
// Simple operations and divide by zero pass through the setup and finish
// steps before the result is registered; multiply and divide run setup,
// sixteen iteration passes through the shared 18-bit adder, post and
// finish. A new request is taken only after the previous item's finish.
// req_ready is high only while idle; synchronous reset clears the accumulator.
// A held result stalls the finish step, where the accumulator also updates.
module saturating_accumulator_alu16
   import sacc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_op,
   input  wire logic [15:0] req_operand,
   input  wire logic        req_write_back,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_result,
   output logic             rsp_saturated,
   output logic             rsp_divide_by_zero
);

   state_type        state_ff, state_in;
   logic [3:0]       op_ff, op_in;
   logic [15:0]      a_ff, a_in;
   logic [15:0]      b_ff, b_in;
   logic             wb_ff, wb_in;
   logic [16:0]      hi_ff, hi_in;
   logic [15:0]      lo_ff, lo_in;
   logic [15:0]      mcand_ff, mcand_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      res_ff, res_in;
   logic             sat_ff, sat_in;
   logic             dz_ff, dz_in;
   logic [15:0]      acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_result_ff, rsp_result_in;
   logic             rsp_sat_ff, rsp_sat_in;
   logic             rsp_dz_ff, rsp_dz_in;

   unit_word_type    unit_x, unit_y, unit_sum;
   logic             unit_sub;
   logic [16:0]      div_shift;
   logic [15:0]      abs_a, abs_b;
   logic [31:0]      mag;
   logic             out_free;

   sacc_addsub u_addsub (
      .x   (unit_x),
      .y   (unit_y),
      .sub (unit_sub),
      .sum (unit_sum)
   );

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_saturated      = rsp_sat_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_shift = {hi_ff[15:0], lo_ff[15]};
   assign abs_a     = a_ff[15] ? (~a_ff + 16'd1) : a_ff;
   assign abs_b     = b_ff[15] ? (~b_ff + 16'd1) : b_ff;
   assign mag       = (op_ff == OP_MUL) ? {hi_ff[15:0], lo_ff} : {16'd0, lo_ff};

   // Operand selection for the shared adder.
   always_comb begin
      unit_x   = {{2{a_ff[15]}}, a_ff};
      unit_y   = {{2{b_ff[15]}}, b_ff};
      unit_sub = 1'b0;
      if (state_ff == ST_ITER) begin
         if (op_ff == OP_MUL) begin
            unit_x = {1'b0, hi_ff};
            unit_y = {2'b00, mcand_ff};
         end else begin
            unit_x   = {1'b0, div_shift};
            unit_y   = {2'b00, mcand_ff};
            unit_sub = 1'b1;
         end
      end else begin
         case (op_ff)
            OP_SUB: begin
               unit_sub = 1'b1;
            end
            OP_INC: begin
               unit_y = {{(UNIT_W-1){1'b0}}, 1'b1};
            end
            OP_DEC: begin
               unit_y   = {{(UNIT_W-1){1'b0}}, 1'b1};
               unit_sub = 1'b1;
            end
            default: begin
               unit_sub = 1'b0;
            end
         endcase
      end
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      wb_in         = wb_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      mcand_in      = mcand_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      sat_in        = sat_ff;
      dz_in         = dz_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      rsp_sat_in    = rsp_sat_ff;
      rsp_dz_in     = rsp_dz_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               a_in     = acc_ff;
               b_in     = req_operand;
               wb_in    = req_write_back;
               state_in = ST_SETUP;
            end
         end

         // Simple operations and divide by zero compute their result here; multiply
         // and divide load their magnitudes and start iterating.
         ST_SETUP: begin
            sat_in   = 1'b0;
            dz_in    = 1'b0;
            res_in   = a_ff;
            state_in = ST_FINISH;
            hi_in    = 17'd0;
            cnt_in   = '0;
            neg_in   = a_ff[15] ^ b_ff[15];
            case (op_ff)
               OP_LOAD: res_in = b_ff;
               OP_AND:  res_in = a_ff & b_ff;
               OP_OR:   res_in = a_ff | b_ff;
               OP_XOR:  res_in = a_ff ^ b_ff;
               OP_NOT:  res_in = ~a_ff;
               OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                  if (unit_sum[16] != unit_sum[15]) begin
                     sat_in = 1'b1;
                     res_in = unit_sum[16] ? SAT_MIN : SAT_MAX;
                  end else begin
                     res_in = unit_sum[15:0];
                  end
               end
               OP_MUL: begin
                  lo_in    = abs_b;
                  mcand_in = abs_a;
                  state_in = ST_ITER;
               end
               OP_DIV: begin
                  if (b_ff == 16'd0) begin
                     dz_in  = 1'b1;
                     res_in = (a_ff == 16'd0) ? 16'd0 : SAT_MAX;
                  end else begin
                     lo_in    = abs_a;
                     mcand_in = abs_b;
                     state_in = ST_ITER;
                  end
               end
               default: res_in = a_ff;
            endcase
         end

         // One shift-add or one restoring divide step per cycle.
         ST_ITER: begin
            if (op_ff == OP_MUL) begin
               if (lo_ff[0]) begin
                  hi_in = {1'b0, unit_sum[16:1]};
                  lo_in = {unit_sum[0], lo_ff[15:1]};
               end else begin
                  hi_in = {1'b0, hi_ff[16:1]};
                  lo_in = {hi_ff[0], lo_ff[15:1]};
               end
            end else begin
               if (!unit_sum[UNIT_W-1]) begin
                  hi_in = unit_sum[16:0];
                  lo_in = {lo_ff[14:0], 1'b1};
               end else begin
                  hi_in = div_shift;
                  lo_in = {lo_ff[14:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ITER_N - 1)) begin
               state_in = ST_POST;
            end
         end

         // Apply the sign and clamp the magnitude to the 16-bit range.
         ST_POST: begin
            state_in = ST_FINISH;
            if (neg_ff) begin
               if (mag > 32'd32768) begin
                  sat_in = 1'b1;
                  res_in = SAT_MIN;
               end else begin
                  res_in = ~mag[15:0] + 16'd1;
               end
            end else begin
               if (mag > 32'd32767) begin
                  sat_in = 1'b1;
                  res_in = SAT_MAX;
               end else begin
                  res_in = mag[15:0];
               end
            end
         end

         // Hand the result to the output register and write back.
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               rsp_sat_in    = sat_ff;
               rsp_dz_in     = dz_ff;
               if (wb_ff) begin
                  acc_in = res_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and accumulator.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 16'd0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      wb_ff         <= wb_in;
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      mcand_ff      <= mcand_in;
      neg_ff        <= neg_in;
      res_ff        <= res_in;
      sat_ff        <= sat_in;
      dz_ff         <= dz_in;
      rsp_result_ff <= rsp_result_in;
      rsp_sat_ff    <= rsp_sat_in;
      rsp_dz_ff     <= rsp_dz_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/sacc_checker.sv @@
`default_nettype none

// Port-level checks for the saturating accumulator.
module sacc_checker
   import sacc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [3:0]  req_op,
   input wire logic [15:0] req_operand,
   input wire logic        req_write_back,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_result,
   input wire logic        rsp_saturated,
   input wire logic        rsp_divide_by_zero
);

   // A waiting request keeps its payload until the transfer.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=>
         req_valid && $stable({req_op, req_operand, req_write_back}))
      else $error("request changed while waiting");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("result changed while stalled");

   // The block works on one item at a time after a transfer.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an input transfer");

   // A clamped result sits at one of the limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_result == SAT_MAX || rsp_result == SAT_MIN)
      else $error("saturated result is not a limit");

   // Divide by zero gives zero or the positive limit and never saturates.
   a_dz_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |->
         !rsp_saturated && (rsp_result == 16'd0 || rsp_result == SAT_MAX))
      else $error("bad divide by zero result");

endmodule

bind saturating_accumulator_alu16 sacc_checker u_sacc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_op             (req_op),
   .req_operand        (req_operand),
   .req_write_back     (req_write_back),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result         (rsp_result),
   .rsp_saturated      (rsp_saturated),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

`default_nettype wire

@@ sim/alu_result_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the ALU, keeps its own accumulator, predicts the
// result of every accepted request and compares every accepted response.
module alu_result_checker
   import sacc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [3:0]  req_op,
   input  wire logic [15:0] req_operand,
   input  wire logic        req_write_back,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [15:0] rsp_result,
   input  wire logic        rsp_saturated,
   input  wire logic        rsp_divide_by_zero,
   output int               error_count,
   output int               pending_count
);

   typedef struct packed {
      logic [15:0] result;
      logic        saturated;
      logic        divide_by_zero;
   } alu_result_type;

   localparam int SHORT_MAX_I = int'($signed(SAT_MAX));
   localparam int SHORT_MIN_I = int'($signed(SAT_MIN));

   alu_result_type expected_results[$];
   logic [15:0]    model_acc;

   // Computes the result of one operation on the given accumulator value.
   function automatic alu_result_type predict_alu(input logic [3:0] op,
                                                  input logic [15:0] operand,
                                                  input logic [15:0] acc);
      int             a;
      int             b;
      int             wide;
      logic           do_clamp;
      alu_result_type r;
      a = $signed(acc);
      b = $signed(operand);
      wide = a;
      do_clamp = 1'b0;
      r.result = acc;
      r.saturated = 1'b0;
      r.divide_by_zero = 1'b0;
      case (op)
         OP_LOAD: r.result = operand;
         OP_AND:  r.result = acc & operand;
         OP_OR:   r.result = acc | operand;
         OP_XOR:  r.result = acc ^ operand;
         OP_NOT:  r.result = ~acc;
         OP_ADD: begin
            wide = a + b;
            do_clamp = 1'b1;
         end
         OP_SUB: begin
            wide = a - b;
            do_clamp = 1'b1;
         end
         OP_MUL: begin
            wide = a * b;
            do_clamp = 1'b1;
         end
         OP_DIV: begin
            if (b == 0) begin
               // A zero divisor is flagged, not clamped.
               r.divide_by_zero = 1'b1;
               r.result = (a == 0) ? 16'h0000 : SAT_MAX;
            end else begin
               wide = a / b;
               do_clamp = 1'b1;
            end
         end
         OP_INC: begin
            if (acc == SAT_MAX) r.saturated = 1'b1;
            else r.result = acc + 16'd1;
         end
         OP_DEC: begin
            if (acc == SAT_MIN) r.saturated = 1'b1;
            else r.result = acc - 16'd1;
         end
         default: r.result = acc;
      endcase
      // Clamp arithmetic results to the signed 16-bit range.
      if (do_clamp) begin
         if (wide > SHORT_MAX_I) begin
            r.result = SAT_MAX;
            r.saturated = 1'b1;
         end else if (wide < SHORT_MIN_I) begin
            r.result = SAT_MIN;
            r.saturated = 1'b1;
         end else begin
            r.result = wide[15:0];
         end
      end
      return r;
   endfunction

   // Both channels are sampled at the rising edge; stimulus moves on the falling one.
   always @(posedge clock) begin
      alu_result_type predicted;
      alu_result_type oldest;
      if (reset) begin
         model_acc = '0;
         expected_results.delete();
      end else begin
         // A request transfer produces one expected response.
         if (req_valid && req_ready) begin
            predicted = predict_alu(req_op, req_operand, model_acc);
            expected_results.push_back(predicted);
            if (req_write_back) model_acc = predicted.result;
         end
         // A response transfer is checked against the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $error("unexpected response: result %0d", $signed(rsp_result));
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_result !== oldest.result) begin
                  error_count++;
                  $error("result mismatch: expected %0d, actual %0d",
                         $signed(oldest.result), $signed(rsp_result));
               end
               if (rsp_saturated !== oldest.saturated) begin
                  error_count++;
                  $error("saturated mismatch: expected %0b, actual %0b",
                         oldest.saturated, rsp_saturated);
               end
               if (rsp_divide_by_zero !== oldest.divide_by_zero) begin
                  error_count++;
                  $error("divide_by_zero mismatch: expected %0b, actual %0b",
                         oldest.divide_by_zero, rsp_divide_by_zero);
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import sacc_pkg::*;

   localparam int          RANDOM_ITEMS   = 1125;
   localparam int          IDLE_LIMIT     = 4000;
   localparam int          DRAIN_CYCLES   = 40;
   localparam logic [3:0]  OP_UNUSED_LO   = OP_DEC + 4'd1;
   localparam logic [3:0]  OP_UNUSED_HI   = 4'hF;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_op = OP_LOAD;
   logic [15:0] req_operand = '0;
   logic        req_write_back = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_result;
   logic        rsp_saturated;
   logic        rsp_divide_by_zero;

   int error_count;
   int pending_count;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int idle_cycles = 0;

   saturating_accumulator_alu16 dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_operand        (req_operand),
      .req_write_back     (req_write_back),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result         (rsp_result),
      .rsp_saturated      (rsp_saturated),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   alu_result_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_operand        (req_operand),
      .req_write_back     (req_write_back),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result         (rsp_result),
      .rsp_saturated      (rsp_saturated),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random according to the current phase.
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Presents one request, with random sender gaps, and holds it until transfer.
   task automatic send_alu_op(input logic [3:0] op, input logic [15:0] operand,
                              input logic write_back);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_operand    <= operand;
      req_write_back <= write_back;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Picks an operand: limits, values near zero, or anything at all.
   function automatic logic [15:0] pick_operand();
      int kind;
      kind = $urandom_range(99);
      if (kind < 20) begin
         case ($urandom_range(6))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return SAT_MAX - 16'd1;
            3: return SAT_MIN + 16'd1;
            4: return 16'hFFFF;
            5: return 16'h0001;
            default: return 16'h0000;
         endcase
      end else if (kind < 55) begin
         return 16'($signed($urandom_range(600)) - 300);
      end else begin
         return 16'($urandom);
      end
   endfunction

   initial begin
      logic [3:0] op;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: limits, every operation and the corner cases.
      send_alu_op(OP_LOAD, 16'h0000, 1'b1);
      send_alu_op(OP_DIV,  16'h0000, 1'b0);   // zero over zero
      send_alu_op(OP_LOAD, SAT_MAX, 1'b1);
      send_alu_op(OP_INC,  16'h0000, 1'b0);   // increment at the top
      send_alu_op(OP_ADD,  16'h0001, 1'b0);
      send_alu_op(OP_MUL,  16'h0002, 1'b0);   // positive product overflow
      send_alu_op(OP_MUL,  16'hFFFE, 1'b0);   // negative product overflow
      send_alu_op(OP_SUB,  SAT_MIN, 1'b0);
      send_alu_op(OP_DIV,  16'h0000, 1'b0);   // positive over zero
      send_alu_op(OP_AND,  16'h00FF, 1'b0);
      send_alu_op(OP_OR,   16'h8000, 1'b0);
      send_alu_op(OP_XOR,  16'hFFFF, 1'b0);
      send_alu_op(OP_NOT,  16'h1234, 1'b0);
      send_alu_op(OP_LOAD, SAT_MIN, 1'b1);
      send_alu_op(OP_DEC,  16'h0000, 1'b0);   // decrement at the bottom
      send_alu_op(OP_DIV,  16'hFFFF, 1'b0);   // most negative over minus one
      send_alu_op(OP_DIV,  16'h0000, 1'b0);   // negative over zero
      send_alu_op(OP_SUB,  16'h0001, 1'b0);
      send_alu_op(OP_ADD,  16'hFFFF, 1'b0);
      send_alu_op(OP_DIV,  16'h0007, 1'b0);
      send_alu_op(OP_LOAD, 16'hFFF9, 1'b1);
      send_alu_op(OP_DIV,  16'h0002, 1'b0);   // truncation toward zero
      send_alu_op(OP_UNUSED_LO, 16'hAAAA, 1'b1);
      send_alu_op(OP_UNUSED_HI, 16'h5555, 1'b0);
      send_alu_op(OP_MUL,  16'h0000, 1'b1);
      send_alu_op(OP_INC,  16'hFFFF, 1'b1);
      send_alu_op(OP_DEC,  16'hFFFF, 1'b1);

      // Random part in four idling phases.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ((i * 4) / RANDOM_ITEMS)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 35; rsp_stall_pct = 35; end
         endcase
         if ($urandom_range(99) < 6) op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
         else op = 4'($urandom_range(OP_DEC, OP_LOAD));
         send_alu_op(op, pick_operand(), $urandom_range(99) < 60);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain the remaining responses, then let the pipeline settle.
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/sacc_pkg.sv
rtl/core/sacc_addsub.sv
rtl/core/saturating_accumulator_alu16.sv
rtl/core/sacc_checker.sv
sim/alu_result_checker.sv
sim/tb.sv
